FILE: hw/rtl/ptig_pkg.sv
// Shared types and constants for the primitive triangulation index generator.
package ptig_pkg;

   // Index width on the result channel
   localparam int unsigned IDX_W = 16;

   // Command queue between front and back
   localparam int unsigned QUE_DEPTH = 4;
   localparam int unsigned QUE_PTR_W = $clog2(QUE_DEPTH);

   // Primitive mode register codes
   typedef enum logic [1:0] {
      MODE_QUADS      = 2'd0,
      MODE_QUAD_STRIP = 2'd1,
      MODE_POLYGON    = 2'd2,
      MODE_PASS       = 2'd3
   } prim_mode_type;

   // Kind of index run the back end has to expand
   typedef enum logic [2:0] {
      CMD_QUADS = 3'd0,
      CMD_STRIP = 3'd1,
      CMD_FAN   = 3'd2,
      CMD_PASS  = 3'd3,
      CMD_OVF   = 3'd4
   } cmd_kind_type;

   // One queued command: run kind and its base index
   typedef struct packed {
      cmd_kind_type      kind;
      logic [IDX_W-1:0]  idx;
   } cmd_type;

endpackage

FILE: hw/rtl/ptig_front.sv
// Front end: numbers vertices in the batch and classifies each into an index run.
module ptig_front #(
   parameter int unsigned MAX_VERTS = 65536
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_first_vertex,
   output logic                    req_stall,
   input  ptig_pkg::prim_mode_type prim_mode,
   input  logic                    que_full,
   output logic                    que_push,
   output ptig_pkg::cmd_type       que_cmd
);
   import ptig_pkg::*;

   localparam int unsigned CNT_W = $clog2(MAX_VERTS + 1);

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic [CNT_W-1:0] vidx;
   logic             accept;
   logic             ovf;
   logic             emits;

   assign req_stall = que_full;
   assign accept    = req_valid && !que_full;

   // Index of the arriving vertex; restart puts it at zero
   assign vidx = req_first_vertex ? '0 : count_ff;
   assign ovf  = (vidx >= CNT_W'(MAX_VERTS));

   // Does this vertex complete a primitive under the current mode
   always_comb begin
      emits = 1'b0;
      if (ovf) begin
         emits = 1'b1;
      end else begin
         unique case (prim_mode)
            MODE_QUADS:      emits = (vidx[1:0] == 2'b11);
            MODE_QUAD_STRIP: emits = (vidx >= CNT_W'(3)) && vidx[0];
            MODE_POLYGON:    emits = (vidx >= CNT_W'(2));
            MODE_PASS:       emits = 1'b1;
            default:         emits = 1'b0;
         endcase
      end
   end

   // Command toward the back end
   always_comb begin
      que_cmd.kind = CMD_PASS;
      que_cmd.idx  = IDX_W'(vidx);
      if (ovf) begin
         que_cmd.kind = CMD_OVF;
         que_cmd.idx  = '0;
      end else begin
         unique case (prim_mode)
            MODE_QUADS: begin
               que_cmd.kind = CMD_QUADS;
               que_cmd.idx  = IDX_W'(vidx) - IDX_W'(3);
            end
            MODE_QUAD_STRIP: begin
               que_cmd.kind = CMD_STRIP;
               que_cmd.idx  = IDX_W'(vidx) - IDX_W'(3);
            end
            MODE_POLYGON: que_cmd.kind = CMD_FAN;
            MODE_PASS:    que_cmd.kind = CMD_PASS;
            default:      que_cmd.kind = CMD_PASS;
         endcase
      end
   end

   assign que_push = accept && emits;

   // Batch counter, saturating at capacity
   assign count_in = ovf ? CNT_W'(MAX_VERTS) : vidx + CNT_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (accept) begin
         count_ff <= count_in;
      end
   end

endmodule

FILE: hw/rtl/ptig_queue.sv
// Short command queue decoupling the front end from the back end.
module ptig_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ptig_pkg::cmd_type push_cmd,
   input  logic              pop,
   output ptig_pkg::cmd_type head_cmd,
   output logic              empty,
   output logic              full
);
   import ptig_pkg::*;

   cmd_type              slot_ff [QUE_DEPTH];
   logic [QUE_PTR_W-1:0] wr_ptr_ff;
   logic [QUE_PTR_W-1:0] rd_ptr_ff;
   logic [QUE_PTR_W:0]   fill_ff;
   logic [QUE_PTR_W:0]   fill_in;
   logic                 do_push;
   logic                 do_pop;

   assign empty    = (fill_ff == '0);
   assign full     = (fill_ff == (QUE_PTR_W+1)'(QUE_DEPTH));
   assign head_cmd = slot_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      fill_in = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + (QUE_PTR_W+1)'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - (QUE_PTR_W+1)'(1);
      end
   end

   // Pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= wr_ptr_ff + QUE_PTR_W'(1);
         if (do_pop)  rd_ptr_ff <= rd_ptr_ff + QUE_PTR_W'(1);
         fill_ff <= fill_in;
      end
   end

   // Storage, no reset needed
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

FILE: hw/rtl/ptig_back.sv
// Back end: expands each queued command into its run of result beats.
module ptig_back (
   input  logic                   clock,
   input  logic                   reset,
   input  ptig_pkg::cmd_type      head_cmd,
   input  logic                   head_valid,
   output logic                   que_pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [ptig_pkg::IDX_W-1:0] rsp_vert_index,
   output logic                   rsp_last_of_run,
   output logic                   rsp_overflow
);
   import ptig_pkg::*;

   logic [2:0]       step_ff;
   logic [2:0]       step_in;
   logic [2:0]       last_step;
   logic [1:0]       offset;
   logic [IDX_W-1:0] idx_in;
   logic             ovf_in;
   logic             last_in;
   logic             load;
   logic             valid_ff;
   logic [IDX_W-1:0] idx_ff;
   logic             last_ff;
   logic             ovf_ff;

   assign load = !valid_ff || !rsp_stall;

   // Per-kind run length and index for the current step
   always_comb begin
      last_step = 3'd0;
      offset    = 2'd0;
      idx_in    = head_cmd.idx;
      ovf_in    = 1'b0;
      unique case (head_cmd.kind)
         CMD_QUADS: begin
            last_step = 3'd5;
            case (step_ff)
               3'd1:    offset = 2'd1;
               3'd2:    offset = 2'd2;
               3'd4:    offset = 2'd2;
               3'd5:    offset = 2'd3;
               default: offset = 2'd0;
            endcase
            idx_in = head_cmd.idx + IDX_W'(offset);
         end
         CMD_STRIP: begin
            last_step = 3'd5;
            case (step_ff)
               3'd1:    offset = 2'd1;
               3'd2:    offset = 2'd3;
               3'd4:    offset = 2'd3;
               3'd5:    offset = 2'd2;
               default: offset = 2'd0;
            endcase
            idx_in = head_cmd.idx + IDX_W'(offset);
         end
         CMD_FAN: begin
            last_step = 3'd2;
            case (step_ff)
               3'd0:    idx_in = '0;
               3'd1:    idx_in = head_cmd.idx - IDX_W'(1);
               default: idx_in = head_cmd.idx;
            endcase
         end
         CMD_PASS: last_step = 3'd0;
         CMD_OVF: begin
            last_step = 3'd0;
            idx_in    = '0;
            ovf_in    = 1'b1;
         end
         default: last_step = 3'd0;
      endcase
   end

   assign last_in = (step_ff == last_step);
   assign que_pop = load && head_valid && last_in;
   assign step_in = last_in ? 3'd0 : step_ff + 3'd1;

   // Step counter and output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= '0;
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= head_valid;
         if (head_valid) step_ff <= step_in;
      end
   end

   // Output payload register
   always_ff @(posedge clock) begin
      if (load && head_valid) begin
         idx_ff  <= idx_in;
         last_ff <= last_in;
         ovf_ff  <= ovf_in;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_vert_index  = idx_ff;
   assign rsp_last_of_run = last_ff;
   assign rsp_overflow    = ovf_ff;

endmodule

FILE: hw/rtl/primitive_triangulation_index_gen.sv
// Top level: mode register, front end, command queue and back end.
// Throughput: one vertex per cycle in while the queue is not full, one result beat per
// cycle out while rsp_stall is low; the back end's expander sets the rate in beats per
// vertex: quads 1.5, quad strip 3, polygon 3, pass-through 1.
// A four-entry command queue lets the front end take vertices while results wait.
// Synchronous reset clears the batch count, queue and output valid; mode resets to pass.
module primitive_triangulation_index_gen #(
   parameter int unsigned MAX_VERTS = 65536
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_wr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_first_vertex,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_vert_index,
   output logic        rsp_last_of_run,
   output logic        rsp_overflow
);
   import ptig_pkg::*;

   prim_mode_type mode_ff;
   logic          que_push;
   logic          que_pop;
   logic          que_empty;
   logic          que_full;
   cmd_type       push_cmd;
   cmd_type       head_cmd;

   // Mode register
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_PASS;
      end else if (csr_wr_en) begin
         mode_ff <= prim_mode_type'(csr_wr_data);
      end
   end

   ptig_front #(
      .MAX_VERTS (MAX_VERTS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_first_vertex (req_first_vertex),
      .req_stall        (req_stall),
      .prim_mode        (mode_ff),
      .que_full         (que_full),
      .que_push         (que_push),
      .que_cmd          (push_cmd)
   );

   ptig_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (que_push),
      .push_cmd (push_cmd),
      .pop      (que_pop),
      .head_cmd (head_cmd),
      .empty    (que_empty),
      .full     (que_full)
   );

   ptig_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_cmd        (head_cmd),
      .head_valid      (!que_empty),
      .que_pop         (que_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_vert_index  (rsp_vert_index),
      .rsp_last_of_run (rsp_last_of_run),
      .rsp_overflow    (rsp_overflow)
   );

`ifndef ASSERT_OFF
   // Overflow beat is always a single-beat run with a zero index
   a_ovf_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflow |-> rsp_last_of_run && (rsp_vert_index == '0))
      else $error("overflow beat malformed");

   // A run continues without a bubble: its command stays queued until the last beat
   a_run_gapless: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_of_run |=> rsp_valid)
      else $error("bubble inside an index run");

   // Front end never pushes into a full queue
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      que_push |-> !que_full)
      else $error("push into full command queue");

   // Mid-run the command queue cannot be empty
   a_head_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_of_run |-> !que_empty)
      else $error("run head lost from queue");
`endif

endmodule

FILE: verif/ptig_index_checker.sv
`timescale 1ns / 1ps
// Checker for the index generator: predicts result beats from accepted vertices and compares.
module ptig_index_checker #(
   parameter int unsigned MAX_VERTS = 65536
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_wr_data,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic        req_first_vertex,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [15:0] rsp_vert_index,
   input  logic        rsp_last_of_run,
   input  logic        rsp_overflow,
   output int unsigned fail_count,
   output int unsigned pending_beats
);
   import ptig_pkg::*;

   // One expected result beat
   typedef struct packed {
      logic [15:0] vert_index;
      logic        last_of_run;
      logic        overflow;
   } index_beat_type;

   index_beat_type expected_beats[$];
   prim_mode_type  prim_mode = MODE_PASS;
   logic [16:0]    batch_count = '0;
   int unsigned    mismatches = 0;
   int unsigned    waiting = 0;

   assign fail_count    = mismatches;
   assign pending_beats = waiting;

   // Number the vertex within its batch and queue the indices it completes
   task automatic predict_vertex_indices(input logic restart);
      logic [16:0]    vtx;
      logic [15:0]    base;
      logic [15:0]    run [6];
      int             n;
      index_beat_type beat;
      n = 0;
      if (restart) batch_count = '0;
      if (batch_count >= MAX_VERTS) begin
         // past capacity: count saturates, one flagged beat
         batch_count      = 17'(MAX_VERTS);
         beat.vert_index  = '0;
         beat.last_of_run = 1'b1;
         beat.overflow    = 1'b1;
         expected_beats.insert(expected_beats.size(), beat);
      end else begin
         vtx         = batch_count;
         batch_count = batch_count + 17'd1;
         base        = vtx[15:0] - 16'd3;
         case (prim_mode)
            MODE_QUADS: begin
               if (vtx[1:0] == 2'b11) begin
                  run[0] = base;         run[1] = base + 16'd1; run[2] = base + 16'd2;
                  run[3] = base;         run[4] = base + 16'd2; run[5] = base + 16'd3;
                  n = 6;
               end
            end
            MODE_QUAD_STRIP: begin
               if (vtx >= 17'd3 && vtx[0]) begin
                  run[0] = base;         run[1] = base + 16'd1; run[2] = base + 16'd3;
                  run[3] = base;         run[4] = base + 16'd3; run[5] = base + 16'd2;
                  n = 6;
               end
            end
            MODE_POLYGON: begin
               // fan around vertex zero
               if (vtx >= 17'd2) begin
                  run[0] = '0;
                  run[1] = vtx[15:0] - 16'd1;
                  run[2] = vtx[15:0];
                  n = 3;
               end
            end
            default: begin
               run[0] = vtx[15:0];
               n = 1;
            end
         endcase
         for (int k = 0; k < n; k++) begin
            beat.vert_index  = run[k];
            beat.last_of_run = (k == n - 1);
            beat.overflow    = 1'b0;
            expected_beats.insert(expected_beats.size(), beat);
         end
      end
   endtask

   // Sample both channels at the edge; results are popped before new vertices are predicted
   always @(posedge clock) begin
      index_beat_type want;
      if (reset) begin
         prim_mode   = MODE_PASS;
         batch_count = '0;
         expected_beats.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_beats.size() == 0) begin
               $error("unexpected result beat: vert_index %0d last_of_run %0b overflow %0b",
                      rsp_vert_index, rsp_last_of_run, rsp_overflow);
               mismatches++;
            end else begin
               want = expected_beats.pop_front();
               if (rsp_vert_index !== want.vert_index) begin
                  $error("vert_index: expected %0d, actual %0d", want.vert_index,
                         rsp_vert_index);
                  mismatches++;
               end
               if (rsp_last_of_run !== want.last_of_run) begin
                  $error("last_of_run: expected %0b, actual %0b", want.last_of_run,
                         rsp_last_of_run);
                  mismatches++;
               end
               if (rsp_overflow !== want.overflow) begin
                  $error("overflow: expected %0b, actual %0b", want.overflow, rsp_overflow);
                  mismatches++;
               end
            end
         end
         if (req_valid && !req_stall) predict_vertex_indices(req_first_vertex);
         if (csr_wr_en) prim_mode = prim_mode_type'(csr_wr_data);
      end
      waiting <= expected_beats.size();
   end

endmodule

FILE: verif/tb_primitive_triangulation_index_gen.sv
`timescale 1ns / 1ps
// Testbench top: drives vertex beats and mode writes, paces the result side, gives the verdict.
module tb_primitive_triangulation_index_gen;
   import ptig_pkg::*;

   localparam int unsigned BATCH_CAPACITY = 65536;
   localparam int unsigned SETTLE_CYCLES  = 12;
   localparam int unsigned LONG_HOLD      = 200;
   localparam int unsigned IDLE_LIMIT     = 2000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [1:0]  csr_wr_data = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_first_vertex = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [15:0] rsp_vert_index;
   logic        rsp_last_of_run;
   logic        rsp_overflow;

   int unsigned fail_count;
   int unsigned pending_beats;

   // sender pacing and receiver hold-off
   int          burst_left = 0;
   logic        hold_req = 1'b0;
   logic        hold_done = 1'b0;
   int unsigned hold_left = 0;
   int unsigned pattern_left = 0;
   int unsigned stall_pct = 0;
   int unsigned idle_cycles = 0;

   primitive_triangulation_index_gen #(
      .MAX_VERTS (BATCH_CAPACITY)
   ) DUT (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_first_vertex (req_first_vertex),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_vert_index   (rsp_vert_index),
      .rsp_last_of_run  (rsp_last_of_run),
      .rsp_overflow     (rsp_overflow)
   );

   ptig_index_checker #(
      .MAX_VERTS (BATCH_CAPACITY)
   ) u_checker (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_first_vertex (req_first_vertex),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_vert_index   (rsp_vert_index),
      .rsp_last_of_run  (rsp_last_of_run),
      .rsp_overflow     (rsp_overflow),
      .fail_count       (fail_count),
      .pending_beats    (pending_beats)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Offer one vertex beat and wait for it to be taken; each burst ends in a gap with req_valid low
   task automatic send_vertex(input logic restart);
      int gap;
      req_valid        <= 1'b1;
      req_first_vertex <= restart;
      do @(posedge clock); while (req_stall);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         gap = $urandom_range(1, 6);
         repeat (gap) @(posedge clock);
         burst_left = $urandom_range(0, 24);
      end
   endtask

   task automatic send_vertices(input int count);
      repeat (count) send_vertex(1'b0);
   endtask

   // Stop offering, then wait until every expected beat is out and the block has settled
   task automatic drain(input int unsigned settle);
      if (req_valid) req_valid <= 1'b0;
      @(posedge clock);
      while (pending_beats != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_mode(input prim_mode_type mode);
      drain(SETTLE_CYCLES);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= mode;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Receiver: long hold-off once on request, otherwise a stall rate that changes now and then
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_req && !hold_done) begin
         rsp_stall <= 1'b1;
         hold_left <= LONG_HOLD;
         hold_done <= 1'b1;
      end else begin
         if (pattern_left == 0) begin
            stall_pct    <= $urandom_range(0, 3) * 30;
            pattern_left <= $urandom_range(20, 80);
         end else begin
            pattern_left <= pattern_left - 1;
         end
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   // Watchdog on cycles with no beat accepted on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
         $display("[primitive_triangulation_index_gen] ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Stimulus
   initial begin
      prim_mode_type phase_modes [4];
      prim_mode_type mode;
      int            items;
      phase_modes = '{MODE_QUADS, MODE_PASS, MODE_QUAD_STRIP, MODE_POLYGON};

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset mode is pass-through; numbering starts at zero without a restart
      send_vertex(1'b0);
      send_vertex(1'b0);
      send_vertex(1'b1);
      write_mode(MODE_QUADS);
      send_vertex(1'b1);
      send_vertices(7);
      write_mode(MODE_QUAD_STRIP);
      send_vertex(1'b1);
      send_vertices(5);
      write_mode(MODE_POLYGON);
      send_vertex(1'b1);
      send_vertices(4);

      // random phases; restarts are rare so most beats complete primitives
      for (int phase = 0; phase < 12; phase++) begin
         mode = (phase < 4) ? phase_modes[phase] : prim_mode_type'($urandom_range(0, 3));
         write_mode(mode);
         // pass-through phase: hold the receiver off so the block backs up into its input
         if (phase == 1) hold_req <= 1'b1;
         items = $urandom_range(20, 36);
         if ($urandom_range(0, 1) == 1) begin
            send_vertex(1'b1);
            items--;
         end
         repeat (items) send_vertex($urandom_range(0, 15) == 0);
      end

      drain(SETTLE_CYCLES + 8);
      if (fail_count == 0) begin
         $display("[primitive_triangulation_index_gen] OK");
      end else begin
         $display("[primitive_triangulation_index_gen] ERROR");
      end
      $finish;
   end

endmodule
